FILE: hw/rtl/lbc_pkg.sv
package lbc_pkg;

    localparam int CACHE_ENTRIES  = 32;
    localparam int BLOCK_NUM_BITS = 16;

    localparam int IDX_W       = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(CACHE_ENTRIES + 1);
    localparam int IN_BLOCK_W  = 16;
    localparam int SLOT_W      = 5;
    localparam int OUT_BLOCK_W = 16;

    typedef logic [BLOCK_NUM_BITS-1:0] tag_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [RANK_W-1:0]         rank_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lbc_cmd_t;

endpackage

FILE: hw/rtl/lbc_req_if.sv
interface lbc_req_if;
    logic                              valid;
    logic                              ready;
    logic [lbc_pkg::IN_BLOCK_W-1:0]    block_number;

    modport source (output valid, output block_number, input ready);
    modport sink   (input valid, input block_number, output ready);
endinterface

FILE: hw/rtl/lbc_rsp_if.sv
interface lbc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [lbc_pkg::SLOT_W-1:0]        slot;
    logic                              evicted_valid;
    logic [lbc_pkg::OUT_BLOCK_W-1:0]   evicted_block;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_block, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_block, output ready);
endinterface

FILE: hw/rtl/lbc_ctrl.sv
module lbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lbc_pkg::lbc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register is free when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while result register is occupied");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed word not presented");

    a_lookup_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |=> state_reg == ST_COMMIT)
        else $error("lookup not followed by commit");

endmodule

FILE: hw/rtl/lbc_datapath.sv
module lbc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbc_pkg::lbc_cmd_t                   cmd,
    input  logic [lbc_pkg::IN_BLOCK_W-1:0]      block_number,
    output logic                                hit,
    output logic [lbc_pkg::SLOT_W-1:0]          slot,
    output logic                                evicted_valid,
    output logic [lbc_pkg::OUT_BLOCK_W-1:0]     evicted_block
);

    localparam int N = lbc_pkg::CACHE_ENTRIES;

    lbc_pkg::tag_t  tag_reg   [N];
    logic [N-1:0]   valid_reg;
    lbc_pkg::rank_t rank_reg  [N];
    lbc_pkg::cnt_t  fill_count_reg;

    lbc_pkg::tag_t  key_reg;

    // Registered lookup decision.
    logic           hit_reg;
    logic           evict_reg;
    logic           fill_reg;
    lbc_pkg::idx_t  target_reg;
    lbc_pkg::cnt_t  limit_reg;
    lbc_pkg::tag_t  victim_tag_reg;

    // Result register.
    logic                               res_hit_reg;
    logic [lbc_pkg::SLOT_W-1:0]         res_slot_reg;
    logic                               res_ev_valid_reg;
    logic [lbc_pkg::OUT_BLOCK_W-1:0]    res_ev_block_reg;

    logic           match_any;
    logic           full;
    lbc_pkg::idx_t  found_idx;
    lbc_pkg::idx_t  free_idx;
    lbc_pkg::idx_t  victim_idx;

    assign full = (fill_count_reg == lbc_pkg::cnt_t'(N));

    // Tag compare against every slot, plus first free slot and the LRU slot.
    // Ranks of valid slots are distinct, so once full the victim is the one
    // holding the oldest rank.
    always_comb
    begin
        match_any  = 1'b0;
        found_idx  = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == key_reg))
            begin
                match_any = 1'b1;
                found_idx = lbc_pkg::idx_t'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = lbc_pkg::idx_t'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == lbc_pkg::rank_t'(N - 1)))
            begin
                victim_idx = lbc_pkg::idx_t'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= lbc_pkg::tag_t'(block_number);
        end
        if (cmd.lookup)
        begin
            hit_reg        <= match_any;
            fill_reg       <= !match_any && !full;
            evict_reg      <= !match_any && full;
            victim_tag_reg <= tag_reg[victim_idx];
            if (match_any)
            begin
                target_reg <= found_idx;
                limit_reg  <= lbc_pkg::cnt_t'(rank_reg[found_idx]);
            end
            else if (!full)
            begin
                target_reg <= free_idx;
                limit_reg  <= lbc_pkg::cnt_t'(N);
            end
            else
            begin
                target_reg <= victim_idx;
                limit_reg  <= lbc_pkg::cnt_t'(rank_reg[victim_idx]);
            end
        end
        if (cmd.commit)
        begin
            res_hit_reg      <= hit_reg;
            res_slot_reg     <= lbc_pkg::SLOT_W'(target_reg);
            res_ev_valid_reg <= evict_reg;
            res_ev_block_reg <= evict_reg ? lbc_pkg::OUT_BLOCK_W'(victim_tag_reg) : '0;
            tag_reg[target_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            fill_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (target_reg == lbc_pkg::idx_t'(i))
                begin
                    valid_reg[i] <= 1'b1;
                    rank_reg[i]  <= '0;
                end
                else if (valid_reg[i] && (lbc_pkg::cnt_t'(rank_reg[i]) < limit_reg))
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            if (fill_reg)
            begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
        end
    end

    assign hit           = res_hit_reg;
    assign slot          = res_slot_reg;
    assign evicted_valid = res_ev_valid_reg;
    assign evicted_block = res_ev_block_reg;

    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == fill_count_reg)
        else $error("fill count disagrees with valid bits");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= lbc_pkg::cnt_t'(N))
        else $error("fill count above capacity");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg) |=> $stable(fill_count_reg))
        else $error("fill count changed on a hit");

endmodule

FILE: hw/rtl/lru_block_cache_tags.sv
// Fully associative LRU tag store for a disk block cache. Each word on req
// carries a block number; each word on rsp reports hit, the slot now holding
// the block, and on an eviction the block number that was thrown out. One
// request is handled at a time, in three steps: capture, a registered
// tag compare across all slots that also picks the free or least recently
// used slot, and an update of the tags and recency ranks that loads the
// result register. A new request is accepted while the previous result still
// waits; the update of that new request stalls until the result is taken.
// Reset clears all valid bits at once, so no clearing pass is needed.
module lru_block_cache_tags (
    input  logic        clk,
    input  logic        rst_n,
    lbc_req_if.sink     req,
    lbc_rsp_if.source   rsp
);

    lbc_pkg::lbc_cmd_t cmd;

    lbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    lbc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .block_number  (req.block_number),
        .hit           (rsp.hit),
        .slot          (rsp.slot),
        .evicted_valid (rsp.evicted_valid),
        .evicted_block (rsp.evicted_block)
    );

endmodule

FILE: dv/lru_block_cache_tags_tb.sv
module lru_block_cache_tags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic                            hit;
        logic [lbc_pkg::SLOT_W-1:0]      slot;
        logic                            evicted_valid;
        logic [lbc_pkg::OUT_BLOCK_W-1:0] evicted_block;
    } lookup_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    lbc_req_if req_ch ();
    lbc_rsp_if rsp_ch ();

    lru_block_cache_tags u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the tag store.
    lbc_pkg::tag_t  tag_store [lbc_pkg::CACHE_ENTRIES];
    logic           tag_valid [lbc_pkg::CACHE_ENTRIES];
    lbc_pkg::rank_t tag_rank  [lbc_pkg::CACHE_ENTRIES];
    int             fill_level;

    lookup_outcome_t lookup_outcomes [$];

    int errors         = 0;
    int words_in       = 0;
    int words_out      = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int cycle_count    = 0;
    int hold_cycles    = 0;
    bit idle_on        = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every valid entry younger than limit gets one step older.
    function automatic void age_below(input int limit);
        for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
        begin
            if (tag_valid[i] && int'(tag_rank[i]) < limit)
                tag_rank[i] = tag_rank[i] + 1'b1;
        end
    endfunction

    function automatic lookup_outcome_t cache_lookup(
        input logic [lbc_pkg::IN_BLOCK_W-1:0] blk);
        lbc_pkg::tag_t   key;
        int              found;
        int              target;
        lbc_pkg::rank_t  oldest;
        lookup_outcome_t res;
        key    = lbc_pkg::tag_t'(blk);
        found  = -1;
        target = -1;
        oldest = '0;
        res    = '0;
        for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
        begin
            if (found < 0 && tag_valid[i] && tag_store[i] == key)
                found = i;
        end
        if (found >= 0)
        begin
            age_below(int'(tag_rank[found]));
            tag_rank[found] = '0;
            res.hit  = 1'b1;
            res.slot = found[lbc_pkg::SLOT_W-1:0];
            return res;
        end
        if (fill_level < lbc_pkg::CACHE_ENTRIES)
        begin
            for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
            begin
                if (target < 0 && !tag_valid[i])
                    target = i;
            end
        end
        if (target >= 0)
        begin
            age_below(lbc_pkg::CACHE_ENTRIES);
            tag_valid[target] = 1'b1;
            fill_level++;
        end
        else
        begin
            // The oldest entry goes; on a tie in rank the lowest slot wins.
            for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
            begin
                if (tag_valid[i] && (target < 0 || tag_rank[i] > oldest))
                begin
                    oldest = tag_rank[i];
                    target = i;
                end
            end
            if (target < 0)
                target = 0;
            res.evicted_valid = 1'b1;
            res.evicted_block = lbc_pkg::OUT_BLOCK_W'(tag_store[target]);
            age_below(int'(tag_rank[target]));
        end
        tag_store[target] = key;
        tag_rank[target]  = '0;
        res.slot = target[lbc_pkg::SLOT_W-1:0];
        return res;
    endfunction

    // Words are sampled at the falling edge, where both sides are settled.
    always @(negedge clk)
    begin
        lookup_outcome_t predicted;
        if (rst_n === 1'b1 && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            predicted = cache_lookup(req_ch.block_number);
            lookup_outcomes.push_back(predicted);
            words_in++;
            if (predicted.hit)
                hits_seen++;
            if (predicted.evicted_valid)
                evictions_seen++;
        end
    end

    always @(negedge clk)
    begin
        lookup_outcome_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            words_out++;
            if (lookup_outcomes.size() == 0)
            begin
                $error("result word with nothing pending: hit %0b slot %0d",
                       rsp_ch.hit, rsp_ch.slot);
                errors++;
            end
            else
            begin
                want = lookup_outcomes.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
                    errors++;
                end
                if (rsp_ch.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
                    errors++;
                end
                if (rsp_ch.evicted_valid !== want.evicted_valid)
                begin
                    $error("evicted_valid: expected %0b, got %0b",
                           want.evicted_valid, rsp_ch.evicted_valid);
                    errors++;
                end
                if (rsp_ch.evicted_block !== want.evicted_block)
                begin
                    $error("evicted_block: expected 0x%04h, got 0x%04h",
                           want.evicted_block, rsp_ch.evicted_block);
                    errors++;
                end
            end
        end
    end

    // Result side: a counted hold-off takes priority over random stalls.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (idle_on)
                rsp_ch.ready <= ($urandom_range(99) >= 35);
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_block(input logic [lbc_pkg::IN_BLOCK_W-1:0] blk);
        bit taken;
        while (idle_on && $urandom_range(99) < 35)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.block_number <= blk;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (req_ch.ready === 1'b1);
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (lookup_outcomes.size() != 0);
    endtask

    // Extremes of the block number, a hit on the newest entry and hits on old ones.
    task automatic test_directed();
        logic [lbc_pkg::IN_BLOCK_W-1:0] corner_blocks [15] = '{
            16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
            16'h7FFF, 16'hAAAA, 16'h5555, 16'h5555, 16'hFFFF,
            16'hFFFE, 16'h0000, 16'h00FF, 16'hFF00, 16'h8000
        };
        foreach (corner_blocks[i])
            send_block(corner_blocks[i]);
    endtask

    // Fill the store, hit every entry in reverse order, then cycle through one
    // block more than fits, twice; each access of the second pass evicts the oldest.
    task automatic test_lru_scan();
        logic [lbc_pkg::IN_BLOCK_W-1:0] base;
        logic [lbc_pkg::IN_BLOCK_W-1:0] stride;
        base   = lbc_pkg::IN_BLOCK_W'($urandom_range(0, 65535));
        stride = 16'h0805;
        for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
            send_block(lbc_pkg::IN_BLOCK_W'(base + i * stride));
        for (int i = lbc_pkg::CACHE_ENTRIES - 1; i >= 0; i--)
            send_block(lbc_pkg::IN_BLOCK_W'(base + i * stride));
        repeat (2)
        begin
            for (int i = 0; i <= lbc_pkg::CACHE_ENTRIES; i++)
                send_block(lbc_pkg::IN_BLOCK_W'(base + i * stride));
        end
    endtask

    // The result side holds off while requests keep coming, so the block stalls
    // its input; afterwards the sender waits for every result.
    task automatic test_backpressure();
        logic [lbc_pkg::IN_BLOCK_W-1:0] pool [8];
        foreach (pool[i])
            pool[i] = lbc_pkg::IN_BLOCK_W'($urandom_range(0, 65535));
        hold_cycles = 150;
        repeat (40)
            send_block(pool[$urandom_range(0, 7)]);
        drain_results();
    endtask

    task automatic test_working_set(input int n_items, input int pool_size, input int hot_pct);
        logic [lbc_pkg::IN_BLOCK_W-1:0] pool [64];
        for (int i = 0; i < pool_size; i++)
            pool[i] = lbc_pkg::IN_BLOCK_W'($urandom_range(0, 65535));
        repeat (n_items)
        begin
            if ($urandom_range(99) < hot_pct)
                send_block(pool[$urandom_range(0, pool_size - 1)]);
            else
                send_block(lbc_pkg::IN_BLOCK_W'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < lbc_pkg::CACHE_ENTRIES; i++)
        begin
            tag_store[i] = '0;
            tag_valid[i] = 1'b0;
            tag_rank[i]  = '0;
        end
        fill_level = 0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.block_number <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        drain_results();
        test_lru_scan();
        test_backpressure();
        idle_on = 1'b0;
        test_working_set(250, 24, 85);
        idle_on = 1'b1;
        test_working_set(400, 40, 80);
        test_working_set(200, 64, 70);
        drain_results();
        repeat (20) @(posedge clk);

        $display("Checked %0d lookups (%0d results): %0d hits, %0d evictions.",
                 words_in, words_out, hits_seen, evictions_seen);
        $display("Covered corner block numbers, LRU scans, an output stall and working sets.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
